// ===== hdl/dfrb_pkg.sv =====
// Package for the delimited frame receive buffer.
// Transfer payload structs, framer/walker state codes and register indexes.
// No dependencies.
package dfrb_pkg;

  typedef enum logic [0:0] {
    OP_RX  = 1'b0,
    OP_POP = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    CFG_START_DELIM = 1'b0,
    CFG_END_DELIM   = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SKIP_RD,
    ST_SKIP_CHK,
    ST_PAY_RD,
    ST_PAY_CHK
  } state_e;

  localparam int unsigned CfgW          = 8;
  localparam logic [7:0]  StartDelimRst = 8'd36;
  localparam logic [7:0]  EndDelimRst   = 8'd58;
  localparam logic [4:0]  MaxLen        = 5'd31;

  typedef struct packed {
    op_e        operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_summary;
    logic [4:0] frame_length;
    logic       frame_ok;
    logic       last;
  } out_item_t;

endpackage

// ===== hdl/dfrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dfrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/delimited_frame_receive_buffer_top.sv =====
// Delimited frame receive buffer: framer, ring store and pop walker.
// Depends on dfrb_pkg and dfrb_ram.
//
// A pop walks the ring from the read pointer with one RAM read port and one
// byte compare: every ring entry it visits takes a read state, then a compare
// state; a walk that runs into the write pointer ends in one more read state,
// and the walk also waits on any output stall.
// Input stall stays high for the whole walk. Each pop ends with one summary
// transfer (last set) carrying the length and ok flag; payload transfers
// come before it. There is no overrun check: writes wrap over unread data.
module delimited_frame_receive_buffer_top #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [0:0]              cfg_idx_i,
  input  logic [dfrb_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  dfrb_pkg::in_item_t      in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output dfrb_pkg::out_item_t     out_item_o
);

  localparam int unsigned PtrW = $clog2(RING_DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(RING_DEPTH - 1);

  dfrb_pkg::state_e    state_q, state_d;
  logic [PtrW-1:0]     rd_q, rd_d, wr_q, wr_d;
  logic                in_frame_q, in_frame_d;
  logic [4:0]          len_q, len_d;
  logic [7:0]          start_q, end_q;
  logic                out_valid_q, out_valid_d;
  dfrb_pkg::out_item_t out_q, out_d;

  logic            ram_we, ram_re;
  logic [7:0]      ram_rdata;
  logic            out_free;
  logic [PtrW-1:0] rd_adv, wr_adv;

  assign rd_adv = (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
  assign wr_adv = (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  dfrb_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_q),
    .wdata_i(in_item_i.rx_byte),
    .re_i   (ram_re),
    .raddr_i(rd_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= dfrb_pkg::StartDelimRst;
      end_q   <= dfrb_pkg::EndDelimRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dfrb_pkg::CFG_START_DELIM: start_q <= cfg_wdata_i;
        dfrb_pkg::CFG_END_DELIM:   end_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dfrb_pkg::ST_IDLE;
      rd_q        <= '0;
      wr_q        <= '0;
      in_frame_q  <= 1'b0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      in_frame_q  <= in_frame_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    in_frame_d  = in_frame_q;
    len_d       = len_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    unique case (state_q)
      dfrb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.operation == dfrb_pkg::OP_POP) begin
            len_d   = '0;
            state_d = dfrb_pkg::ST_SKIP_RD;
          end else if (!in_frame_q) begin
            if (in_item_i.rx_byte == start_q) begin
              ram_we     = 1'b1;
              wr_d       = wr_adv;
              in_frame_d = 1'b1;
            end
          end else begin
            ram_we = 1'b1;
            wr_d   = wr_adv;
            if (in_item_i.rx_byte == end_q) begin
              in_frame_d = 1'b0;
            end
          end
        end
      end

      dfrb_pkg::ST_SKIP_RD, dfrb_pkg::ST_PAY_RD: begin
        if (rd_q == wr_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_d       = '{data_byte: 8'd0, is_summary: 1'b1, frame_length: 5'd0,
                            frame_ok: 1'b0, last: 1'b1};
            state_d     = dfrb_pkg::ST_IDLE;
          end
        end else begin
          ram_re  = 1'b1;
          state_d = (state_q == dfrb_pkg::ST_SKIP_RD) ? dfrb_pkg::ST_SKIP_CHK
                                                      : dfrb_pkg::ST_PAY_CHK;
        end
      end

      dfrb_pkg::ST_SKIP_CHK: begin
        rd_d    = rd_adv;
        state_d = (ram_rdata == start_q) ? dfrb_pkg::ST_PAY_RD : dfrb_pkg::ST_SKIP_RD;
      end

      dfrb_pkg::ST_PAY_CHK: begin
        if (ram_rdata == end_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_d       = '{data_byte: 8'd0, is_summary: 1'b1, frame_length: len_q,
                            frame_ok: 1'b1, last: 1'b1};
            rd_d        = rd_adv;
            state_d     = dfrb_pkg::ST_IDLE;
          end
        end else if (len_q != dfrb_pkg::MaxLen) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_d       = '{data_byte: ram_rdata, is_summary: 1'b0, frame_length: 5'd0,
                            frame_ok: 1'b0, last: 1'b0};
            len_d       = len_q + 5'd1;
            rd_d        = rd_adv;
            state_d     = dfrb_pkg::ST_PAY_RD;
          end
        end else begin
          // saturated: consume silently
          rd_d    = rd_adv;
          state_d = dfrb_pkg::ST_PAY_RD;
        end
      end

      default: state_d = dfrb_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != dfrb_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_last_is_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.last == out_item_o.is_summary))
    else $error("last flag does not match summary flag");

  a_data_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.is_summary) |->
      (out_item_o.frame_length == 5'd0 && !out_item_o.frame_ok))
    else $error("data transfer carries summary fields");

  a_pop_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_item_i.operation == dfrb_pkg::OP_POP) |=>
      (state_q == dfrb_pkg::ST_SKIP_RD))
    else $error("pop did not start the ring walk");

  a_wr_stable_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != dfrb_pkg::ST_IDLE) |=> $stable(wr_q))
    else $error("write pointer moved during a walk");

  a_fail_summary_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.is_summary && !out_item_o.frame_ok) |->
      (out_item_o.frame_length == 5'd0))
    else $error("failed pop reports a nonzero length");

endmodule
